[rtl/core/lsl_pkg.sv]
// Shared types, token codes and keyword table for the Lox source lexer.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package lsl_pkg;

    localparam int unsigned MAX_SOURCE_BYTES = 65536;
    localparam int unsigned KW_MAX_LEN       = 6;
    localparam int unsigned KW_COUNT         = 15;
    localparam int unsigned POS_W            = $clog2(MAX_SOURCE_BYTES + 1);
    localparam int unsigned MAX_RES          = 4;
    localparam int unsigned NUM_CAND         = 6;

    // token kinds
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS    = 6'd17;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_END     = 6'd37;

    localparam logic ERR_UNEXPECTED   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_OP2     = 4'd1,
        M_SLASH   = 4'd2,
        M_COMMENT = 4'd3,
        M_STRING  = 4'd4,
        M_NUMBER  = 4'd5,
        M_NUMDOT  = 4'd6,
        M_FRAC    = 4'd7,
        M_WORD    = 4'd8
    } mode_t;

    typedef struct packed {
        mode_t                       mode;
        logic [7:0]                  held;
        logic [POS_W-1:0]            position;
        logic [15:0]                 tstart;
        logic [15:0]                 line;
        logic [KW_MAX_LEN-1:0][7:0]  wbuf;
        logic [15:0]                 wlen;
    } lex_state_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        err;
        logic        code;
    } tok_t;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"c", "l", "a", "s", "s", 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00},
        '{"f", "u", "n", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "i", "l", 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"s", "u", "p", "e", "r", 8'h00},
        '{"t", "h", "i", "s", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{
        16'd3, 16'd5, 16'd4, 16'd5, 16'd3, 16'd2, 16'd3, 16'd2,
        16'd5, 16'd6, 16'd5, 16'd4, 16'd4, 16'd3, 16'd5
    };

    function automatic logic [15:0] clamp16(input logic [17:0] v);
        return (v > 18'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] span(input logic [17:0] e, input logic [15:0] ts);
        logic [17:0] d;
        d = e - {2'b00, ts};
        return (e > {2'b00, ts}) ? clamp16(d) : 16'd0;
    endfunction

    function automatic logic [5:0] op2_base(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            ">":     k = K_GREATER;
            default: k = K_LESS;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                    input logic [15:0] len, input logic [15:0] line,
                                    input logic err, input logic code);
        tok_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.err   = err;
        t.code  = code;
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lox_source_lexer_core.sv]
// Top level of the Lox source lexer: stream ports, lexer state, result bank.
// Depends on lsl_pkg and lsl_step (which uses lsl_kw_match).
//
// Usage:
//   Slave side takes one source byte per beat: s_tdata = byte, s_tlast marks
//   the final byte, s_tuser = 1 for a beat with no byte that only ends the source.
//   Master side returns tokens: m_tdata = kind, start, length, line;
//   m_tuser = error flag and error code; m_tlast marks the last token that a
//   given input beat produced.
//   Latency: the tokens for a beat appear in the cycle after it is accepted.
//   Throughput: one beat per cycle while each beat yields at most one token
//   and m_tready stays high; a beat that yields n tokens (up to four) holds
//   the result bank until all have left, one per cycle while m_tready is high.
//   s_tready is high when the bank is empty or its last token leaves now.
//   A stall on m_tready holds the current token and, while the bank holds
//   tokens, backs up into s_tready; no byte or token is ever dropped.
//   Reset: lexer idle, position 0, line 1, bank empty. After the end token
//   of a source the lexer is back in that state for the next source.
//   Positions saturate at the maximum source size; lines at 65535.
`default_nettype none

module lox_source_lexer_core
    import lsl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // source bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // is_last
    input  wire logic        s_tuser,   // end_only
    // tokens
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [5:0] kind, [21:6] start_res,
                                        // [37:22] length, [53:38] line, [55:54] 0
    output logic             m_tlast,   // last_of_run
    output logic [1:0]       m_tuser    // [0] is_error, [1] error_code
);

    lex_state_t state_reg;
    lex_state_t state_next;
    tok_t       step_res [MAX_RES];
    logic [2:0] step_cnt;

    // result bank: tokens of the last accepted beat, read out in order
    tok_t       bank_reg [MAX_RES];
    logic [2:0] cnt_reg;
    logic [1:0] rd_reg;
    tok_t       cur;

    logic s_beat;
    logic m_beat;

    lsl_step u_step (
        .st       (state_reg),
        .ch       (s_tdata),
        .is_last  (s_tlast),
        .end_only (s_tuser),
        .st_next  (state_next),
        .res      (step_res),
        .res_cnt  (step_cnt)
    );

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_beat   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign s_beat   = s_tvalid && s_tready;

    assign cur     = bank_reg[rd_reg];
    assign m_tdata = {2'b00, cur.line, cur.len, cur.start, cur.kind};
    assign m_tuser = {cur.code, cur.err};
    assign m_tlast = (cnt_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: M_IDLE, held: 8'd0, position: '0, tstart: 16'd0,
                           line: 16'd1, wbuf: '0, wlen: 16'd0};
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            if (s_beat)
            begin
                state_reg <= state_next;
                cnt_reg   <= step_cnt;
                rd_reg    <= '0;
            end
            else if (m_beat)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                rd_reg  <= rd_reg + 2'd1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            for (int i = 0; i < MAX_RES; i++)
                bank_reg[i] <= step_res[i];
        end
    end

    // end of a source always returns the lexer to its reset state
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && (s_tuser || s_tlast) |=>
            (state_reg.mode == M_IDLE) && (state_reg.position == '0) &&
            (state_reg.line == 16'd1))
        else $error("lexer state not cleared after end of source");

    a_bank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(MAX_RES))
        else $error("result bank count out of range");

    a_quiet_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && (step_cnt == 3'd0) |=> !m_tvalid)
        else $error("tokens shown for a beat that produced none");

    a_end_token_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (cur.kind == K_END) && !cur.err |-> m_tlast)
        else $error("end token is not the last of its run");

endmodule

`default_nettype wire

[rtl/core/lsl_kw_match.sv]
// Keyword matcher: maps a buffered word to a keyword kind or identifier.
// Depends on lsl_pkg for the keyword table.
`default_nettype none

module lsl_kw_match
    import lsl_pkg::*;
(
    input  wire logic [KW_MAX_LEN-1:0][7:0] wbuf,
    input  wire logic [15:0]                wlen,
    output logic      [5:0]                 kind
);

    logic hit;

    always_comb
    begin
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (wlen == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if ((16'(i) < KW_LEN[k]) && (wbuf[i] != KW_TEXT[k][i]))
                    hit = 1'b0;
            end
            if (hit)
                kind = K_KW0 + 6'(k);
        end
    end

endmodule

`default_nettype wire

[rtl/core/lsl_step.sv]
// One lexer step: next state and up to four result tokens for one beat.
// Depends on lsl_pkg and lsl_kw_match.
`default_nettype none

module lsl_step
    import lsl_pkg::*;
(
    input  wire lex_state_t       st,
    input  wire logic [7:0]       ch,
    input  wire logic             is_last,
    input  wire logic             end_only,
    output lex_state_t            st_next,
    output tok_t                  res [MAX_RES],
    output logic [2:0]            res_cnt
);

    lex_state_t       mid;
    logic [POS_W-1:0] pos_inc;
    logic [5:0]       kw_cur;
    logic [5:0]       kw_mid;
    tok_t             byte_cand [3];
    logic             byte_cv   [3];
    tok_t             fl_cand   [3];
    logic             fl_cv     [3];
    tok_t             cand [NUM_CAND];
    logic             cv   [NUM_CAND];

    lsl_kw_match u_kw_cur (.wbuf(st.wbuf),  .wlen(st.wlen),  .kind(kw_cur));
    lsl_kw_match u_kw_mid (.wbuf(mid.wbuf), .wlen(mid.wlen), .kind(kw_mid));

    // byte lexing: slots 0..2
    always_comb
    begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] dotp;
        logic             do_idle;
        mid     = st;
        pos     = st.position;
        dotp    = (pos != '0) ? pos - 1'b1 : '0;
        do_idle = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            byte_cand[i] = '0;
            byte_cv[i]   = 1'b0;
        end
        pos_inc = (pos < POS_W'(MAX_SOURCE_BYTES)) ? pos + 1'b1 : pos;
        if (!end_only)
        begin
            unique case (st.mode)
                M_OP2:
                begin
                    byte_cv[0] = 1'b1;
                    if (ch == "=")
                    begin
                        byte_cand[0] = mk_tok(op2_base(st.held) + 6'd1, st.tstart, 16'd2,
                                              st.line, 1'b0, 1'b0);
                        mid.mode     = M_IDLE;
                    end
                    else
                    begin
                        byte_cand[0] = mk_tok(op2_base(st.held), st.tstart, 16'd1,
                                              st.line, 1'b0, 1'b0);
                        do_idle      = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (ch == "/")
                        mid.mode = M_COMMENT;
                    else
                    begin
                        byte_cv[0]   = 1'b1;
                        byte_cand[0] = mk_tok(K_SLASH, st.tstart, 16'd1, st.line,
                                              1'b0, 1'b0);
                        do_idle      = 1'b1;
                    end
                end
                M_COMMENT:
                    do_idle = (ch == CH_LF);
                M_STRING:
                begin
                    if (ch == "\"")
                    begin
                        byte_cv[0]   = 1'b1;
                        byte_cand[0] = mk_tok(K_STRING, st.tstart,
                                              span(18'(pos) + 18'd1, st.tstart),
                                              st.line, 1'b0, 1'b0);
                        mid.mode     = M_IDLE;
                    end
                    else if ((ch == CH_LF) && (st.line != 16'hFFFF))
                        mid.line = st.line + 16'd1;
                end
                M_NUMBER, M_FRAC:
                begin
                    if (ch == "." && st.mode == M_NUMBER)
                        mid.mode = M_NUMDOT;
                    else if (!is_digit(ch))
                    begin
                        byte_cv[0]   = 1'b1;
                        byte_cand[0] = mk_tok(K_NUMBER, st.tstart,
                                              span(18'(pos), st.tstart),
                                              st.line, 1'b0, 1'b0);
                        do_idle      = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(ch))
                        mid.mode = M_FRAC;
                    else
                    begin
                        byte_cv[0]   = 1'b1;
                        byte_cand[0] = mk_tok(K_NUMBER, st.tstart,
                                              span(18'(dotp), st.tstart),
                                              st.line, 1'b0, 1'b0);
                        byte_cv[1]   = 1'b1;
                        byte_cand[1] = mk_tok(K_DOT, clamp16(18'(dotp)), 16'd1,
                                              st.line, 1'b0, 1'b0);
                        do_idle      = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_alpha(ch))
                    begin
                        for (int i = 0; i < KW_MAX_LEN; i++)
                        begin
                            if (st.wlen == 16'(i))
                                mid.wbuf[i] = ch;
                        end
                        if (st.wlen != 16'hFFFF)
                            mid.wlen = st.wlen + 16'd1;
                    end
                    else
                    begin
                        byte_cv[0]   = 1'b1;
                        byte_cand[0] = mk_tok(kw_cur, st.tstart, span(18'(pos), st.tstart),
                                              st.line, 1'b0, 1'b0);
                        do_idle      = 1'b1;
                    end
                end
                default:
                    do_idle = 1'b1;
            endcase

            if (do_idle)
            begin
                mid.mode = M_IDLE;
                unique case (ch)
                    "(", ")", "{", "}", ",", ".", "-", "+", ";", "*":
                    begin
                        byte_cv[2] = 1'b1;
                        unique case (ch)
                            "(":     byte_cand[2].kind = K_LPAREN;
                            ")":     byte_cand[2].kind = K_RPAREN;
                            "{":     byte_cand[2].kind = K_LBRACE;
                            "}":     byte_cand[2].kind = K_RBRACE;
                            ",":     byte_cand[2].kind = K_COMMA;
                            ".":     byte_cand[2].kind = K_DOT;
                            "-":     byte_cand[2].kind = K_MINUS;
                            "+":     byte_cand[2].kind = K_PLUS;
                            ";":     byte_cand[2].kind = K_SEMI;
                            default: byte_cand[2].kind = K_STAR;
                        endcase
                        byte_cand[2].start = clamp16(18'(pos));
                        byte_cand[2].len   = 16'd1;
                        byte_cand[2].line  = st.line;
                    end
                    " ", CH_CR, CH_TAB: ;
                    CH_LF:
                    begin
                        if (st.line != 16'hFFFF)
                            mid.line = st.line + 16'd1;
                    end
                    default:
                    begin
                        mid.tstart = clamp16(18'(pos));
                        if (ch == "!" || ch == "=" || ch == "<" || ch == ">")
                        begin
                            mid.held = ch;
                            mid.mode = M_OP2;
                        end
                        else if (ch == "/")
                            mid.mode = M_SLASH;
                        else if (ch == "\"")
                            mid.mode = M_STRING;
                        else if (is_digit(ch))
                            mid.mode = M_NUMBER;
                        else if (is_alpha(ch))
                        begin
                            mid.mode    = M_WORD;
                            mid.wbuf[0] = ch;
                            mid.wlen    = 16'd1;
                        end
                        else
                        begin
                            byte_cv[2]   = 1'b1;
                            byte_cand[2] = mk_tok(6'd0, clamp16(18'(pos)), 16'd1, st.line,
                                                  1'b1, ERR_UNEXPECTED);
                        end
                    end
                endcase
            end
            mid.position = pos_inc;
        end
    end

    // end-of-source flush: slots 3..5, then back to reset state
    always_comb
    begin
        logic [POS_W-1:0] fend;
        logic [POS_W-1:0] fdot;
        logic             fl;
        fl      = end_only || is_last;
        fend    = end_only ? st.position : pos_inc;
        fdot    = (fend != '0) ? fend - 1'b1 : '0;
        st_next = mid;
        for (int i = 0; i < 3; i++)
        begin
            fl_cand[i] = '0;
            fl_cv[i]   = 1'b0;
        end
        if (fl)
        begin
            unique case (mid.mode)
                M_OP2:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(op2_base(mid.held), mid.tstart, 16'd1,
                                        mid.line, 1'b0, 1'b0);
                end
                M_SLASH:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(K_SLASH, mid.tstart, 16'd1, mid.line, 1'b0, 1'b0);
                end
                M_STRING:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(6'd0, mid.tstart, span(18'(fend), mid.tstart),
                                        mid.line, 1'b1, ERR_UNTERMINATED);
                end
                M_NUMBER, M_FRAC:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(K_NUMBER, mid.tstart, span(18'(fend), mid.tstart),
                                        mid.line, 1'b0, 1'b0);
                end
                M_NUMDOT:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(K_NUMBER, mid.tstart, span(18'(fdot), mid.tstart),
                                        mid.line, 1'b0, 1'b0);
                    fl_cv[1]   = 1'b1;
                    fl_cand[1] = mk_tok(K_DOT, clamp16(18'(fdot)), 16'd1,
                                        mid.line, 1'b0, 1'b0);
                end
                M_WORD:
                begin
                    fl_cv[0]   = 1'b1;
                    fl_cand[0] = mk_tok(kw_mid, mid.tstart, span(18'(fend), mid.tstart),
                                        mid.line, 1'b0, 1'b0);
                end
                default: ;
            endcase
            fl_cv[2]   = 1'b1;
            fl_cand[2] = mk_tok(K_END, clamp16(18'(fend)), 16'd0, mid.line, 1'b0, 1'b0);

            st_next          = '0;
            st_next.mode     = M_IDLE;
            st_next.line     = 16'd1;
        end
    end

    // pack the valid slots in order
    always_comb
    begin
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < 3; i++)
        begin
            cand[i]     = byte_cand[i];
            cv[i]       = byte_cv[i];
            cand[i + 3] = fl_cand[i];
            cv[i + 3]   = fl_cv[i];
        end
        for (int i = 0; i < MAX_RES; i++)
            res[i] = '0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cv[i] && (n < 3'(MAX_RES)))
            begin
                res[n[1:0]] = cand[i];
                n           = n + 3'd1;
            end
        end
        res_cnt = n;
    end

endmodule

`default_nettype wire

[sim/lox_source_lexer_core_tb.sv]
// Self-checking testbench for lox_source_lexer_core: directed source table plus random
// sources, checked beat by beat against a behavioral lexer model. Depends on lsl_pkg.
module lox_source_lexer_core_tb;
    import lsl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        err;
        logic        code;
        logic        last;
    } token_exp_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       endo;
        int         nexp;   // -1: predictor only; else count of typed tokens
        token_exp_t t0;
    } src_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    lox_source_lexer_core i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lexer model state
    mode_t       lx_mode;
    logic [7:0]  lx_held;
    int unsigned lx_pos;
    logic [15:0] lx_tstart;
    logic [15:0] lx_line;
    logic [7:0]  lx_word [KW_MAX_LEN];
    logic [15:0] lx_wlen;

    token_exp_t  tokens_pending[$];
    token_exp_t  run_toks[$];
    int          errors = 0;
    bit          stim_done = 0;

    // keyword spellings kept locally as strings
    string kw_names [15] = '{"and", "class", "else", "false", "fun", "if", "nil", "or",
                             "print", "return", "super", "this", "true", "var", "while"};

    function automatic logic [15:0] sat16(int unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] span_to(int unsigned e);
        return (e > lx_tstart) ? sat16(e - lx_tstart) : 16'd0;
    endfunction

    function automatic logic [5:0] pair_kind(logic [7:0] c);
        case (c)
            "!":     return K_BANG;
            "=":     return K_EQUAL;
            ">":     return K_GREATER;
            default: return K_LESS;
        endcase
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic lx_reset();
        lx_mode = M_IDLE;
        lx_held = '0;
        lx_pos = 0;
        lx_tstart = '0;
        lx_line = 16'd1;
        foreach (lx_word[i]) lx_word[i] = '0;
        lx_wlen = '0;
    endtask

    task automatic push_tok(logic [5:0] k, int unsigned st, int unsigned ln, bit er, bit cd);
        token_exp_t t;
        t.kind = k;
        t.start = sat16(st);
        t.len = sat16(ln);
        t.line = lx_line;
        t.err = er;
        t.code = cd;
        t.last = 1'b0;
        if (run_toks.size() < MAX_RES) run_toks.push_back(t);
    endtask

    task automatic push_word(int unsigned e);
        logic [5:0] k;
        bit hit;
        k = K_IDENT;
        if (lx_wlen <= KW_MAX_LEN)
            for (int i = 0; i < 15; i++)
                if (kw_names[i].len() == lx_wlen && k == K_IDENT)
                begin
                    hit = 1;
                    for (int j = 0; j < lx_wlen; j++)
                        if (lx_word[j] != kw_names[i][j]) hit = 0;
                    if (hit) k = K_KW0 + i;
                end
        push_tok(k, lx_tstart, span_to(e), 0, 0);
    endtask

    task automatic lex_fresh(logic [7:0] c, int unsigned p);
        lx_mode = M_IDLE;
        case (c)
            "(": begin push_tok(K_LPAREN, p, 1, 0, 0); return; end
            ")": begin push_tok(K_RPAREN, p, 1, 0, 0); return; end
            "{": begin push_tok(K_LBRACE, p, 1, 0, 0); return; end
            "}": begin push_tok(K_RBRACE, p, 1, 0, 0); return; end
            ",": begin push_tok(K_COMMA, p, 1, 0, 0); return; end
            ".": begin push_tok(K_DOT, p, 1, 0, 0); return; end
            "-": begin push_tok(K_MINUS, p, 1, 0, 0); return; end
            "+": begin push_tok(K_PLUS, p, 1, 0, 0); return; end
            ";": begin push_tok(K_SEMI, p, 1, 0, 0); return; end
            "*": begin push_tok(K_STAR, p, 1, 0, 0); return; end
            " ", CH_CR, CH_TAB: return;
            CH_LF: begin if (lx_line != 16'hFFFF) lx_line++; return; end
            default: ;
        endcase
        lx_tstart = sat16(p);
        if (c == "!" || c == "=" || c == "<" || c == ">")
        begin
            lx_held = c;
            lx_mode = M_OP2;
        end
        else if (c == "/") lx_mode = M_SLASH;
        else if (c == "\"") lx_mode = M_STRING;
        else if (digit(c)) lx_mode = M_NUMBER;
        else if (alpha(c))
        begin
            lx_mode = M_WORD;
            lx_word[0] = c;
            lx_wlen = 1;
        end
        else push_tok(K_LPAREN, p, 1, 1, ERR_UNEXPECTED);
    endtask

    task automatic lex_next(logic [7:0] c, int unsigned p);
        int unsigned dot;
        dot = (p > 0) ? p - 1 : 0;
        case (lx_mode)
            M_OP2:
            begin
                if (c == "=")
                begin
                    push_tok(pair_kind(lx_held) + 1, lx_tstart, 2, 0, 0);
                    lx_mode = M_IDLE;
                    return;
                end
                push_tok(pair_kind(lx_held), lx_tstart, 1, 0, 0);
            end
            M_SLASH:
            begin
                if (c == "/") begin lx_mode = M_COMMENT; return; end
                push_tok(K_SLASH, lx_tstart, 1, 0, 0);
            end
            M_COMMENT: if (c != CH_LF) return;
            M_STRING:
            begin
                if (c == "\"")
                begin
                    push_tok(K_STRING, lx_tstart, span_to(p + 1), 0, 0);
                    lx_mode = M_IDLE;
                end
                else if (c == CH_LF && lx_line != 16'hFFFF) lx_line++;
                return;
            end
            M_NUMBER:
            begin
                if (digit(c)) return;
                if (c == ".") begin lx_mode = M_NUMDOT; return; end
                push_tok(K_NUMBER, lx_tstart, span_to(p), 0, 0);
            end
            M_NUMDOT:
            begin
                if (digit(c)) begin lx_mode = M_FRAC; return; end
                push_tok(K_NUMBER, lx_tstart, span_to(dot), 0, 0);
                push_tok(K_DOT, dot, 1, 0, 0);
            end
            M_FRAC:
            begin
                if (digit(c)) return;
                push_tok(K_NUMBER, lx_tstart, span_to(p), 0, 0);
            end
            M_WORD:
            begin
                if (alpha(c))
                begin
                    if (lx_wlen < KW_MAX_LEN) lx_word[lx_wlen] = c;
                    if (lx_wlen != 16'hFFFF) lx_wlen++;
                    return;
                end
                push_word(p);
            end
            default: ;
        endcase
        lex_fresh(c, p);
    endtask

    task automatic lex_close(int unsigned e);
        int unsigned dot;
        dot = (e > 0) ? e - 1 : 0;
        case (lx_mode)
            M_OP2:    push_tok(pair_kind(lx_held), lx_tstart, 1, 0, 0);
            M_SLASH:  push_tok(K_SLASH, lx_tstart, 1, 0, 0);
            M_STRING: push_tok(K_LPAREN, lx_tstart, span_to(e), 1, ERR_UNTERMINATED);
            M_NUMBER, M_FRAC: push_tok(K_NUMBER, lx_tstart, span_to(e), 0, 0);
            M_NUMDOT:
            begin
                push_tok(K_NUMBER, lx_tstart, span_to(dot), 0, 0);
                push_tok(K_DOT, dot, 1, 0, 0);
            end
            M_WORD:   push_word(e);
            default: ;
        endcase
        push_tok(K_END, e, 0, 0, 0);
        lx_reset();
    endtask

    // model one accepted beat; leaves the tokens in run_toks
    task automatic lex_beat(logic [7:0] c, bit last, bit endo);
        run_toks.delete();
        if (endo) lex_close(lx_pos);
        else
        begin
            lex_next(c, lx_pos);
            if (lx_pos < MAX_SOURCE_BYTES) lx_pos++;
            if (last) lex_close(lx_pos);
        end
        if (run_toks.size() > 0) run_toks[run_toks.size()-1].last = 1'b1;
    endtask

    // drive one beat with a random lead-in gap, wait for acceptance
    task automatic send_beat(logic [7:0] c, bit last, bit endo);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        s_tuser <= endo;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic run_beat(logic [7:0] c, bit last, bit endo);
        lex_beat(c, last, endo);
        foreach (run_toks[i]) tokens_pending.push_back(run_toks[i]);
        send_beat(c, last, endo);
    endtask

    // random token text biased toward well-formed lexemes
    task automatic random_lexeme(output logic [7:0] buf_q[$]);
        string ops;
        int n;
        buf_q.delete();
        ops = "(){},.-+;*!=<>/";
        case ($urandom_range(0, 11))
            0: buf_q.push_back(ops[$urandom_range(0, ops.len()-1)]);
            1: begin buf_q.push_back(ops[$urandom_range(10, 13)]); buf_q.push_back("="); end
            2: begin
                buf_q = '{"/", "/"};
                repeat ($urandom_range(0, 5)) buf_q.push_back(8'($urandom_range(32, 126)));
                buf_q.push_back(CH_LF);
            end
            3: begin
                buf_q.push_back("\"");
                repeat ($urandom_range(0, 5))
                    buf_q.push_back(($urandom_range(0, 4) == 0) ? CH_LF
                                                                : 8'($urandom_range(35, 126)));
                if ($urandom_range(0, 5) != 0) buf_q.push_back("\"");
            end
            4, 5: begin
                repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 1))
                begin
                    buf_q.push_back(".");
                    repeat ($urandom_range(0, 2))
                        buf_q.push_back(8'($urandom_range("0", "9")));
                end
            end
            6, 7: begin
                n = $urandom_range(0, 14);
                for (int i = 0; i < kw_names[n].len(); i++) buf_q.push_back(kw_names[n][i]);
            end
            8: repeat ($urandom_range(1, 8))
                buf_q.push_back($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                      : 8'($urandom_range("A", "Z")));
            9: buf_q.push_back(8'($urandom_range(0, 255)));
            default: buf_q.push_back(($urandom_range(0, 2) == 0) ? CH_LF : " ");
        endcase
    endtask

    // directed sources; typed expectations where obvious, else predictor
    src_row_t dir_rows[$];

    function automatic src_row_t row(logic [7:0] c, bit l, bit e, int n,
                                     logic [5:0] k = 0, logic [15:0] s = 0,
                                     logic [15:0] ln = 0, logic [15:0] li = 1,
                                     bit er = 0, bit cd = 0);
        src_row_t r;
        r.ch = c;
        r.last = l;
        r.endo = e;
        r.nexp = n;
        r.t0 = '{kind: k, start: s, len: ln, line: li, err: er, code: cd, last: 1'b1};
        return r;
    endfunction

    // stimulus
    initial
    begin
        logic [7:0] lex_q[$];
        int ntok;
        lx_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            row(8'h00, 1, 1, 1, K_END, 0, 0, 1),               // empty source
            row(8'h00, 0, 0, 1, K_LPAREN, 0, 1, 1, 1, ERR_UNEXPECTED),  // NUL
            row(8'hFF, 0, 0, 1, K_LPAREN, 1, 1, 1, 1, ERR_UNEXPECTED),  // top byte
            row("_", 0, 0, 1, K_LPAREN, 2, 1, 1, 1, ERR_UNEXPECTED),
            row("(", 0, 0, 1, K_LPAREN, 3, 1, 1),
            row("1", 0, 0, -1), row("2", 0, 0, -1), row(".", 0, 0, -1),
            row("x", 0, 0, -1),                                 // held dot, no fraction
            row("3", 0, 0, -1), row(".", 0, 0, -1), row("5", 0, 0, -1),
            row(CH_LF, 0, 0, -1),
            row("/", 0, 0, -1), row("/", 0, 0, -1), row("q", 0, 0, -1),
            row(CH_LF, 0, 0, -1),                                // comment newline counts
            row("r", 0, 0, -1), row("e", 0, 0, -1), row("t", 0, 0, -1),
            row("u", 0, 0, -1), row("r", 0, 0, -1), row("n", 0, 0, -1),
            row("!", 0, 0, -1), row("\"", 0, 0, -1), row("a", 1, 0, -1)  // unterminated
        };
        foreach (dir_rows[i])
        begin
            lex_beat(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].endo);
            if (dir_rows[i].nexp == 1 && (run_toks.size() != 1 || run_toks[0] != dir_rows[i].t0))
            begin
                errors++;
                $display("directed row %0d: typed token disagrees with prediction", i);
            end
            foreach (run_toks[j]) tokens_pending.push_back(run_toks[j]);
            send_beat(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].endo);
        end

        // random sources: lexemes until about 95 more beats sent
        ntok = 0;
        while (ntok < 95)
        begin
            random_lexeme(lex_q);
            foreach (lex_q[i])
            begin
                run_beat(lex_q[i], ($urandom_range(0, 40) == 0), 1'b0);
                ntok++;
            end
            if ($urandom_range(0, 12) == 0) begin run_beat(8'h00, 1'b0, 1'b1); ntok++; end
        end
        run_beat(8'h00, 1'b0, 1'b1);
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // token sink with random stall
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // output check
    always @(posedge clk)
    begin
        token_exp_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{kind: m_tdata[5:0], start: m_tdata[21:6], len: m_tdata[37:22],
                    line: m_tdata[53:38], err: m_tuser[0], code: m_tuser[1], last: m_tlast};
            if (tokens_pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected token beat %h", got);
            end
            else
            begin
                want = tokens_pending.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("token mismatch: exp kind %0d st %0d len %0d line %0d err %b/%b last %b, got kind %0d st %0d len %0d line %0d err %b/%b last %b",
                                 want.kind, want.start, want.len, want.line, want.err,
                                 want.code, want.last, got.kind, got.start, got.len,
                                 got.line, got.err, got.code, got.last);
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait (tokens_pending.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("lox_source_lexer_core test passed");
        else
            $display("lox_source_lexer_core test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("lox_source_lexer_core test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lsl_pkg.sv
rtl/core/lsl_kw_match.sv
rtl/core/lsl_step.sv
rtl/core/lox_source_lexer_core.sv
sim/lox_source_lexer_core_tb.sv
